@@ hw/rtl/cwac_pkg.sv @@
// Shared types and constants for the Chinese Wall access checker.
// Used by cwac_lookup, cwac_history and chinese_wall_access_check; no dependencies.
package cwac_pkg;

	localparam int DEF_NUM_SUBJECTS  = 8;
	localparam int DEF_NUM_OBJECTS   = 8;
	localparam int DEF_NUM_COMPANIES = 8;
	localparam int DEF_NUM_CLASSES   = 8;

	localparam int SUBJ_W = 3;
	localparam int OBJ_W  = 3;
	localparam int CODE_W = 4;
	localparam int REG_W  = 32;

	// Codes below CODE_SPAN are real companies or classes, the rest mean none
	localparam int              CODE_SPAN = 8;
	localparam logic [CODE_W-1:0] CODE_NONE = 4'd8;

	localparam logic [REG_W-1:0] OBJ_MAP_RESET   = 32'hFFF2_2110;
	localparam logic [REG_W-1:0] CLASS_MAP_RESET = 32'hFFFF_F100;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} opcode_t;

	typedef enum logic {
		REG_OBJECT_COMPANY = 1'b0,
		REG_COMPANY_CLASS  = 1'b1
	} reg_index_t;

	typedef struct packed {
		opcode_t           opcode;
		logic [SUBJ_W-1:0] subject;
		logic [OBJ_W-1:0]  object;
	} req_t;

endpackage

@@ hw/rtl/cwac_lookup.sv @@
// Map lookup: object to company, company to conflict class, and the company masks.
// Depends on cwac_pkg.
module cwac_lookup import cwac_pkg::*; #(
	parameter int NUM_OBJECTS   = DEF_NUM_OBJECTS,
	parameter int NUM_COMPANIES = DEF_NUM_COMPANIES,
	parameter int NUM_CLASSES   = DEF_NUM_CLASSES,
	localparam int MW = NUM_COMPANIES + 1
) (
	input  logic [REG_W-1:0]  obj_map,
	input  logic [REG_W-1:0]  class_map,
	input  logic [OBJ_W-1:0]  object,
	output logic [CODE_W-1:0] company,
	output logic [MW-1:0]     own,
	output logic [MW-1:0]     members
);

	function automatic logic [CODE_W-1:0] class_code(input logic [REG_W-1:0] map,
			input logic [CODE_W-1:0] comp);
		logic [CODE_W-1:0] k;
		k = map[{comp[2:0], 2'b00} +: CODE_W];
		if (comp >= CODE_NONE || k >= CODE_NONE || int'(k) >= NUM_CLASSES)
			return CODE_NONE;
		return k;
	endfunction

	logic [CODE_W-1:0] c_raw;
	logic [CODE_W-1:0] cls;

	always_comb begin
		c_raw = obj_map[{object, 2'b00} +: CODE_W];
		if (int'(object) < NUM_OBJECTS && c_raw < CODE_NONE && int'(c_raw) < NUM_COMPANIES)
			company = c_raw;
		else
			company = CODE_NONE;
		cls = class_code(class_map, company);

		// top bit stands for "no company", which sits in the none class
		for (int c = 0; c < MW; c++) begin
			if (c == NUM_COMPANIES) begin
				own[c]     = (company == CODE_NONE);
				members[c] = (cls == CODE_NONE);
			end else if (c < CODE_SPAN) begin
				own[c]     = (company == CODE_W'(c));
				members[c] = (class_code(class_map, CODE_W'(c)) == cls);
			end else begin
				own[c]     = 1'b0;
				members[c] = 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/cwac_history.sv @@
// Per-subject access and read history with the grant decision and its update.
// Depends on cwac_pkg.
module cwac_history import cwac_pkg::*; #(
	parameter int NUM_SUBJECTS  = DEF_NUM_SUBJECTS,
	parameter int NUM_COMPANIES = DEF_NUM_COMPANIES,
	localparam int MW = NUM_COMPANIES + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  opcode_t           opcode,
	input  logic [SUBJ_W-1:0] subject,
	input  logic [MW-1:0]     own,
	input  logic [MW-1:0]     members,
	output logic              grant
);

	// only subjects the request field can name get storage
	localparam int DEPTH = (NUM_SUBJECTS < (1 << SUBJ_W)) ? NUM_SUBJECTS : (1 << SUBJ_W);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [MW-1:0] acc_q [DEPTH];
	logic [MW-1:0] rd_q  [DEPTH];

	logic             in_range;
	logic [IDX_W-1:0] idx;
	logic [MW-1:0]    acc;
	logic [MW-1:0]    rd;
	logic             wall_ok;

	always_comb begin
		in_range = int'(subject) < NUM_SUBJECTS;
		idx      = subject[IDX_W-1:0];
		acc      = in_range ? acc_q[idx] : '0;
		rd       = in_range ? rd_q[idx]  : '0;
		wall_ok  = ((acc & members) == '0) || ((acc & own) != '0);
		case (opcode)
			OP_CLEAR: grant = 1'b1;
			OP_READ:  grant = in_range && wall_ok;
			OP_WRITE: grant = in_range && wall_ok && ((rd & members & ~own) == '0);
			default:  grant = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < DEPTH; s++) begin
				acc_q[s] <= '0;
				rd_q[s]  <= '0;
			end
		end else if (fire) begin
			if (opcode == OP_CLEAR) begin
				for (int s = 0; s < DEPTH; s++) begin
					acc_q[s] <= '0;
					rd_q[s]  <= '0;
				end
			end else if (grant && (opcode == OP_READ || opcode == OP_WRITE)) begin
				acc_q[idx] <= acc_q[idx] | own;
				if (opcode == OP_READ)
					rd_q[idx] <= rd_q[idx] | own;
			end
		end
	end

`ifndef SYNTH
	logic                    any_set;
	logic                    subset_ok;
	logic [2*DEPTH*MW-1:0]   hist_flat;

	always_comb begin
		any_set   = 1'b0;
		subset_ok = 1'b1;
		hist_flat = '0;
		for (int s = 0; s < DEPTH; s++) begin
			any_set   = any_set | (|acc_q[s]) | (|rd_q[s]);
			subset_ok = subset_ok & ((rd_q[s] & ~acc_q[s]) == '0);
			hist_flat[2*s*MW +: MW]     = acc_q[s];
			hist_flat[(2*s+1)*MW +: MW] = rd_q[s];
		end
	end

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fire && opcode == OP_CLEAR |=> !any_set)
		else $error("history not empty after clear");

	a_read_within_access: assert property (@(posedge clk) disable iff (!arst_n)
		subset_ok)
		else $error("read mask holds a company missing from the access mask");

	a_refusal_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !grant |=> $stable(hist_flat))
		else $error("refused request changed the history");
`endif

endmodule

@@ hw/rtl/chinese_wall_access_check.sv @@
// Chinese Wall access checker: one request decided per cycle while not stalled.
// Path: stage 1 reads and updates the history, then the result register is loaded.
// Throughput: one request per cycle while the output is not stalled.
// Reset: histories cleared and both maps loaded with their defaults at once.
// Depends on cwac_pkg, cwac_lookup and cwac_history.
module chinese_wall_access_check import cwac_pkg::*; #(
	parameter int NUM_SUBJECTS  = DEF_NUM_SUBJECTS,
	parameter int NUM_OBJECTS   = DEF_NUM_OBJECTS,
	parameter int NUM_COMPANIES = DEF_NUM_COMPANIES,
	parameter int NUM_CLASSES   = DEF_NUM_CLASSES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [REG_W-1:0]  wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic [SUBJ_W-1:0] subject,
	input  logic [OBJ_W-1:0]  object,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              granted,
	output logic [CODE_W-1:0] object_company
);

	localparam int MW = NUM_COMPANIES + 1;

	logic [REG_W-1:0]  obj_map_q;
	logic [REG_W-1:0]  class_map_q;
	req_t              req_s1;
	logic              valid_s1;
	logic              out_valid_q;
	logic              granted_q;
	logic [CODE_W-1:0] company_q;

	logic              advance;
	logic              accept;
	logic              fire;
	logic              grant;
	logic [CODE_W-1:0] company;
	logic [MW-1:0]     own;
	logic [MW-1:0]     members;

	// stage 1 moves on when the result register is empty or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_map_q   <= OBJ_MAP_RESET;
			class_map_q <= CLASS_MAP_RESET;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_OBJECT_COMPANY: obj_map_q   <= wr_data;
				REG_COMPANY_CLASS:  class_map_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// hold a waiting request until it moves on
			valid_s1 <= accept || (valid_s1 && !advance);
			if (advance)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.opcode  <= opcode_t'(opcode);
			req_s1.subject <= subject;
			req_s1.object  <= object;
		end
		if (fire) begin
			granted_q <= grant;
			// clear reports company zero
			company_q <= (req_s1.opcode == OP_CLEAR) ? '0 : company;
		end
	end

	cwac_lookup #(
		.NUM_OBJECTS   (NUM_OBJECTS),
		.NUM_COMPANIES (NUM_COMPANIES),
		.NUM_CLASSES   (NUM_CLASSES)
	) u_lookup (
		.obj_map   (obj_map_q),
		.class_map (class_map_q),
		.object    (req_s1.object),
		.company   (company),
		.own       (own),
		.members   (members)
	);

	cwac_history #(
		.NUM_SUBJECTS  (NUM_SUBJECTS),
		.NUM_COMPANIES (NUM_COMPANIES)
	) u_history (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.opcode  (req_s1.opcode),
		.subject (req_s1.subject),
		.own     (own),
		.members (members),
		.grant   (grant)
	);

	assign out_valid      = out_valid_q;
	assign granted        = granted_q;
	assign object_company = company_q;

endmodule
